[rtl/keyframe_interval_finder_macros.svh]
// Assertion macros for the keyframe interval finder
`ifndef KEYFRAME_INTERVAL_FINDER_MACROS_SVH
`define KEYFRAME_INTERVAL_FINDER_MACROS_SVH
// Implication checked on every clock edge outside reset
`define KIF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the next cycle
`define KIF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/kif_pkg.sv]
// ----------------------------------------------------------------------------
// kif_pkg
// Shared constants and command/status types of the keyframe interval finder.
// ----------------------------------------------------------------------------
package kif_pkg;
  localparam int MAX_FRAMES_DEF  = 256;
  localparam int TIME_BITS_DEF   = 48;
  localparam int FACTOR_BITS_DEF = 16;
  localparam int SLOT_BITS       = 8;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [0:0] REG_LOOP  = 1'b0;
  localparam logic [0:0] REG_COUNT = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input word
    logic wr_mem;    // store keyframe time
    logic rd_last;   // read entry n-1
    logic rd_first;  // read entry 0
    logic rd_mid;    // read entry mid
    logic cap_dur;   // register duration
    logic cap_first; // register first time
    logic cap_mid;   // update lo/hi from mid read
    logic cap_lo;    // register time at lo
    logic cap_hi;    // register time at hi
    logic rd_lo;     // read entry lo
    logic rd_hi;     // read entry hi
    logic mod_init;
    logic mod_step;
    logic mod_done;
    logic div_init_wrap;
    logic div_init_pair;
    logic div_step;
    logic set_invalid;
    logic finish_ok;
    logic fin_wrap;  // pair last frame with first
  } kif_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_query;
    logic t_neg;
    logic dur_zero;
    logic few;
    logic past_end;
    logic before_first;
    logic search_done;
  } kif_sts_t;
endpackage

[rtl/kif_datapath.sv]
// ----------------------------------------------------------------------------
// kif_datapath
// Time table, search bounds, serial modulo and serial fraction divider.
// ----------------------------------------------------------------------------
module kif_datapath #(
  parameter int MAX_FRAMES  = kif_pkg::MAX_FRAMES_DEF,
  parameter int TIME_BITS   = kif_pkg::TIME_BITS_DEF,
  parameter int FACTOR_BITS = kif_pkg::FACTOR_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_opcode,
  input  logic [kif_pkg::SLOT_BITS-1:0]     in_frame_slot,
  input  logic signed [TIME_BITS-1:0]       in_time_value,
  input  logic [8:0]                        frame_count,
  input  kif_pkg::kif_cmd_t                 cmd,
  output kif_pkg::kif_sts_t                 sts,
  output logic                              out_pair_valid,
  output logic [kif_pkg::SLOT_BITS-1:0]     out_earlier_frame,
  output logic [kif_pkg::SLOT_BITS-1:0]     out_later_frame,
  output logic [FACTOR_BITS-1:0]            out_blend_factor
);
  localparam int AW = $clog2(MAX_FRAMES);
  localparam int NW = AW + 1;
  localparam int TB = TIME_BITS;
  localparam int SB = kif_pkg::SLOT_BITS;

  logic [TB-1:0] mem [MAX_FRAMES];
  logic [TB-1:0] rdata_r;
  logic [AW-1:0] raddr;

  logic          op_r;
  logic [SB-1:0] slot_r;
  logic [TB-1:0] t_r, t_nxt;
  logic [NW-1:0] n_r;
  logic [TB-1:0] dur_r, first_r, tlo_r, thi_r;
  logic [NW-1:0] lo_r, hi_r;
  logic [NW-1:0] mid;
  // modulo: restoring, one bit a cycle over the dividend
  logic [TB-1:0] mrem_r, mq_r;
  logic [TB:0]   mtry;
  logic [TB-1:0] ad;
  // fraction divider
  logic [TB:0]   drem_r, dden_r, dsub;
  logic [FACTOR_BITS-1:0] q_r;
  logic          v_r;
  logic [SB-1:0] e_r, l_r;
  logic [NW-1:0] fc_sat;

  assign fc_sat = (frame_count > 9'(MAX_FRAMES)) ? NW'(MAX_FRAMES) : NW'(frame_count);
  assign mid    = NW'((({1'b0, lo_r} + {1'b0, hi_r}) >> 1));

  always_comb begin
    raddr = '0;
    if (cmd.rd_last)  raddr = AW'(n_r - NW'(1));
    if (cmd.rd_first) raddr = '0;
    if (cmd.rd_mid)   raddr = AW'(mid);
    if (cmd.rd_lo)    raddr = AW'(lo_r);
    if (cmd.rd_hi)    raddr = AW'(hi_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_mem && (int'(slot_r) < MAX_FRAMES)) begin
      mem[AW'(slot_r)] <= t_r;
    end
    rdata_r <= mem[raddr];
  end

  assign ad   = dur_r[TB-1] ? (~dur_r + TB'(1)) : dur_r;
  assign mtry = {mrem_r, mq_r[TB-1]} - {1'b0, ad};
  assign dsub = drem_r - (dden_r - drem_r);

  always_comb begin
    t_nxt = t_r;
    if (cmd.mod_done) t_nxt = mrem_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_opcode;
      slot_r <= in_frame_slot;
      t_r    <= in_time_value;
      n_r    <= fc_sat;
      lo_r   <= '0;
      hi_r   <= fc_sat - NW'(1);
    end else begin
      t_r <= t_nxt;
    end
    if (cmd.cap_dur)   dur_r   <= rdata_r;
    if (cmd.cap_first) first_r <= rdata_r;
    if (cmd.cap_lo)    tlo_r   <= rdata_r;
    if (cmd.cap_hi)    thi_r   <= rdata_r;
    if (cmd.cap_mid) begin
      if ($signed(rdata_r) > $signed(t_r)) hi_r <= mid;
      else lo_r <= mid;
    end
    if (cmd.mod_init) begin
      mrem_r <= '0;
      mq_r   <= t_r;
    end else if (cmd.mod_step) begin
      mq_r <= {mq_r[TB-2:0], 1'b0};
      if (!mtry[TB]) mrem_r <= mtry[TB-1:0];
      else mrem_r <= {mrem_r[TB-2:0], mq_r[TB-1]};
    end
    if (cmd.div_init_wrap) begin
      drem_r <= {1'b0, t_r};
      dden_r <= {1'b0, first_r};
      q_r    <= '0;
    end else if (cmd.div_init_pair) begin
      drem_r <= {1'b0, t_r - tlo_r};
      dden_r <= {1'b0, thi_r - tlo_r};
      q_r    <= '0;
    end else if (cmd.div_step) begin
      if (drem_r >= (dden_r - drem_r)) begin
        drem_r <= dsub;
        q_r    <= {q_r[FACTOR_BITS-2:0], 1'b1};
      end else begin
        drem_r <= {drem_r[TB-1:0], 1'b0};
        q_r    <= {q_r[FACTOR_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
      e_r <= '0;
      l_r <= '0;
    end else if (cmd.set_invalid) begin
      v_r <= 1'b0;
      e_r <= '0;
      l_r <= '0;
    end else if (cmd.finish_ok) begin
      v_r <= 1'b1;
      if (cmd.fin_wrap) begin
        e_r <= SB'(n_r - NW'(1));
        l_r <= '0;
      end else begin
        e_r <= SB'(lo_r);
        l_r <= SB'(hi_r);
      end
    end
  end

  assign sts.is_query     = (op_r == kif_pkg::OP_QUERY);
  assign sts.t_neg        = t_r[TB-1];
  assign sts.dur_zero     = (dur_r == '0) || (n_r == '0);
  assign sts.few          = (n_r < NW'(2));
  assign sts.past_end     = !($signed(dur_r) > $signed(t_r));
  assign sts.before_first = $signed(first_r) > $signed(t_r);
  assign sts.search_done  = (hi_r - lo_r) <= NW'(1);

  assign out_pair_valid    = v_r;
  assign out_earlier_frame = v_r ? e_r : '0;
  assign out_later_frame   = v_r ? l_r : '0;
  assign out_blend_factor  = v_r ? q_r : '0;
endmodule

[rtl/kif_ctrl.sv]
// ----------------------------------------------------------------------------
// kif_ctrl
// Sequencer for writes, modulo, binary search and fraction division.
// ----------------------------------------------------------------------------
`include "keyframe_interval_finder_macros.svh"
module kif_ctrl #(
  parameter int TIME_BITS   = kif_pkg::TIME_BITS_DEF,
  parameter int FACTOR_BITS = kif_pkg::FACTOR_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              loop_en,
  input  kif_pkg::kif_sts_t sts,
  output kif_pkg::kif_cmd_t cmd,
  output logic              busy,
  output logic              out_strobe
);
  localparam int CW = $clog2(TIME_BITS + 1);
  localparam logic [3:0] S_IDLE  = 4'd0, S_DEC = 4'd1, S_RDUR = 4'd2, S_CDUR = 4'd3,
    S_MOD = 4'd4, S_RFST = 4'd5, S_CFST = 4'd6, S_CHK = 4'd7, S_SRCH = 4'd8,
    S_SCAP = 4'd9, S_RLO = 4'd10, S_RHI = 4'd11, S_CHI = 4'd12, S_DIV = 4'd13,
    S_DONE = 4'd14, S_OUT = 4'd15;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          wrap_r, wrap_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    wrap_nxt  = wrap_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (!sts.is_query) begin
          cmd.wr_mem = 1'b1;
          cmd.set_invalid = 1'b1;
          state_nxt = S_OUT;
        end else if (sts.t_neg) begin
          cmd.set_invalid = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.rd_last = 1'b1;
          state_nxt = S_RDUR;
        end
      end
      S_RDUR: begin
        cmd.cap_dur = 1'b1;
        state_nxt = S_CDUR;
      end
      S_CDUR: begin
        if (loop_en) begin
          if (sts.dur_zero) begin
            cmd.set_invalid = 1'b1;
            state_nxt = S_OUT;
          end else begin
            cmd.mod_init = 1'b1;
            cnt_nxt = CW'(TIME_BITS);
            state_nxt = S_MOD;
          end
        end else begin
          state_nxt = S_RFST;
        end
      end
      S_MOD: begin
        if (cnt_r == '0) begin
          cmd.mod_done = 1'b1;
          state_nxt = S_RFST;
        end else begin
          cmd.mod_step = 1'b1;
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      S_RFST: begin
        cmd.rd_first = 1'b1;
        state_nxt = S_CFST;
      end
      S_CFST: begin
        cmd.cap_first = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.few || sts.past_end) begin
          cmd.set_invalid = 1'b1;
          state_nxt = S_OUT;
        end else if (sts.before_first) begin
          if (!loop_en) begin
            cmd.set_invalid = 1'b1;
            state_nxt = S_OUT;
          end else begin
            cmd.div_init_wrap = 1'b1;
            wrap_nxt = 1'b1;
            cnt_nxt = CW'(FACTOR_BITS);
            state_nxt = S_DIV;
          end
        end else begin
          wrap_nxt = 1'b0;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (sts.search_done) begin
          cmd.rd_lo = 1'b1;
          state_nxt = S_RLO;
        end else begin
          cmd.rd_mid = 1'b1;
          state_nxt = S_SCAP;
        end
      end
      S_SCAP: begin
        cmd.cap_mid = 1'b1;
        state_nxt = S_SRCH;
      end
      S_RLO: begin
        cmd.cap_lo = 1'b1;
        cmd.rd_hi = 1'b1;
        state_nxt = S_RHI;
      end
      S_RHI: begin
        cmd.cap_hi = 1'b1;
        state_nxt = S_CHI;
      end
      S_CHI: begin
        cmd.div_init_pair = 1'b1;
        cnt_nxt = CW'(FACTOR_BITS);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.finish_ok = 1'b1;
        cmd.fin_wrap = wrap_r;
        state_nxt = S_OUT;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      wrap_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      wrap_r  <= wrap_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = (state_r == S_OUT);

  `KIF_ASSERT_NEXT(a_start_leaves_idle, start && !busy, state_r == S_DEC, "start not taken")
  `KIF_ASSERT_NEXT(a_strobe_one, out_strobe, !out_strobe, "strobe held over two cycles")
  `KIF_ASSERT_IMP(a_idle_quiet, !busy, !out_strobe, "strobe while idle")
endmodule

[rtl/keyframe_interval_finder.sv]
// ----------------------------------------------------------------------------
// keyframe_interval_finder
// Keyframe table with binary search for the bracketing pair and blend weight.
// ----------------------------------------------------------------------------
// channel | handshake            | words
// input   | start / busy         | in_opcode, in_frame_slot, in_time_value
// result  | out_strobe (1 cycle) | out_pair_valid, out_earlier_frame, ...
// config  | APB write/read       | loop_enable @0, frame_count @4
// A write is stored in the decode state and answered with an invalid result. A query's run
// time is set by the serial modulo (one bit a cycle), the binary search and the serial divider.
// The table RAM has one read port; each search probe issues a read, then captures the entry.
// Synchronous active-low reset clears control, config and result registers; datapath working
// registers and table contents are not reset. Results cannot be stalled.
module keyframe_interval_finder #(
  parameter int MAX_FRAMES  = kif_pkg::MAX_FRAMES_DEF,
  parameter int TIME_BITS   = kif_pkg::TIME_BITS_DEF,
  parameter int FACTOR_BITS = kif_pkg::FACTOR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_opcode,
  input  logic [kif_pkg::SLOT_BITS-1:0] in_frame_slot,
  input  logic signed [TIME_BITS-1:0]   in_time_value,
  output logic                          out_strobe,
  output logic                          out_pair_valid,
  output logic [kif_pkg::SLOT_BITS-1:0] out_earlier_frame,
  output logic [kif_pkg::SLOT_BITS-1:0] out_later_frame,
  output logic [FACTOR_BITS-1:0]        out_blend_factor,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  logic              cfg_loop_enable_r;
  logic [8:0]        cfg_frame_count_r;
  logic              wr_en;
  kif_pkg::kif_cmd_t cmd;
  kif_pkg::kif_sts_t sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_loop_enable_r <= 1'b0;
      cfg_frame_count_r <= '0;
    end else if (wr_en) begin
      if (paddr[2] == kif_pkg::REG_LOOP && paddr[1:0] == 2'b00) cfg_loop_enable_r <= pwdata[0];
      if (paddr[2] == kif_pkg::REG_COUNT && paddr[1:0] == 2'b00) cfg_frame_count_r <= pwdata[8:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == kif_pkg::REG_LOOP) prdata = {31'd0, cfg_loop_enable_r};
    else prdata = {23'd0, cfg_frame_count_r};
  end

  kif_ctrl #(.TIME_BITS(TIME_BITS), .FACTOR_BITS(FACTOR_BITS)) u_ctrl (
    .clk, .rst_n, .start, .loop_en(cfg_loop_enable_r), .sts, .cmd, .busy, .out_strobe
  );

  kif_datapath #(
    .MAX_FRAMES(MAX_FRAMES), .TIME_BITS(TIME_BITS), .FACTOR_BITS(FACTOR_BITS)
  ) u_dp (
    .clk, .rst_n, .in_opcode, .in_frame_slot, .in_time_value,
    .frame_count(cfg_frame_count_r), .cmd, .sts,
    .out_pair_valid, .out_earlier_frame, .out_later_frame, .out_blend_factor
  );
endmodule

[tb/sv/tb_keyframe_interval_finder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyframe_interval_finder
// Writes keyframe tables (mostly ascending), sets loop mode and frame count over
// the configuration port, then queries playback times. Each result word is
// checked field by field against a local model of the bracketing search and
// the blend weight.
// ----------------------------------------------------------------------------
module tb_keyframe_interval_finder;
  localparam int NFR = 256;
  localparam int FB  = 16;
  localparam logic [2:0] ADDR_LOOP  = 3'd0;
  localparam logic [2:0] ADDR_COUNT = 3'd4;

  typedef struct {
    logic       op;
    logic [7:0] slot;
    logic [47:0] tv;
  } word_t;

  typedef struct {
    logic        pv;
    logic [7:0]  ef;
    logic [7:0]  lf;
    logic [15:0] bf;
  } pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_opcode = 1'b0;
  logic [7:0] in_frame_slot = '0;
  logic signed [47:0] in_time_value = '0;
  logic out_strobe, out_pair_valid;
  logic [7:0] out_earlier_frame, out_later_frame;
  logic [15:0] out_blend_factor;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  keyframe_interval_finder dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  word_t pending_words[$];
  pair_t expected_pairs[$];
  logic signed [63:0] key_times[NFR];
  logic model_loop = 1'b0;
  logic [8:0] model_count = '0;
  int errors = 0;
  int send_idle_pct = 0;
  int cycles = 0;
  bit driving = 1'b0;
  logic busy_at_edge = 1'b1;

  task automatic report_mismatch(input string what, input longint got, input longint exp);
    $display("mismatch %s: got %0h expected %0h", what, got, exp);
    errors++;
  endtask

  function automatic logic [15:0] blend_weight(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q, rem;
    q = 0;
    rem = num;
    for (int i = 0; i < FB; i++) begin
      q = q << 1;
      if (rem >= den - rem) begin
        rem = rem - (den - rem);
        q[0] = 1'b1;
      end else begin
        rem = rem << 1;
      end
    end
    return q[15:0];
  endfunction

  function automatic pair_t find_pair(input word_t w);
    pair_t r;
    logic signed [63:0] t, dur, first;
    logic [63:0] ad;
    int n, lo, hi, mid;
    r = '{1'b0, 8'd0, 8'd0, 16'd0};
    if (w.op == kif_pkg::OP_WRITE) begin
      key_times[w.slot] = {{16{w.tv[47]}}, w.tv};
      return r;
    end
    t = {{16{w.tv[47]}}, w.tv};
    if (t < 0) return r;
    n = model_count > NFR ? NFR : model_count;
    dur = n >= 1 ? key_times[n-1] : 0;
    if (model_loop) begin
      ad = dur < 0 ? -dur : dur;
      if (ad == 0) return r;
      t = $signed(64'(t) % ad);
    end
    if (n < 2 || !(dur > t)) return r;
    first = key_times[0];
    if (first > t) begin
      if (!model_loop) return r;
      r = '{1'b1, 8'(n - 1), 8'd0, blend_weight(t, first)};
      return r;
    end
    lo = 0;
    hi = n - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (key_times[mid] > t) hi = mid;
      else lo = mid;
    end
    r = '{1'b1, 8'(lo), 8'(hi),
          blend_weight(t - key_times[lo], key_times[hi] - key_times[lo])};
    return r;
  endfunction

  // driver: present a word at the falling edge, move to the next once accepted
  always @(negedge clk) begin
    if (rst_n && driving) begin
      if (start && !busy_at_edge) begin
        void'(pending_words.pop_front());
      end
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        start <= 1'b1;
        in_opcode <= pending_words[0].op;
        in_frame_slot <= pending_words[0].slot;
        in_time_value <= pending_words[0].tv;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // record acceptance at the rising edge, predict from the accepted word
  always @(posedge clk) begin
    busy_at_edge <= busy;
    cycles++;
    if (rst_n && start && !busy)
      expected_pairs.insert(expected_pairs.size(),
                            find_pair('{in_opcode, in_frame_slot, in_time_value}));
  end

  // monitor
  always @(posedge clk) begin
    pair_t e;
    if (rst_n && out_strobe) begin
      if (expected_pairs.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        e = expected_pairs.pop_front();
        if (out_pair_valid !== e.pv) report_mismatch("pair_valid", out_pair_valid, e.pv);
        if (out_earlier_frame !== e.ef)
          report_mismatch("earlier_frame", out_earlier_frame, e.ef);
        if (out_later_frame !== e.lf) report_mismatch("later_frame", out_later_frame, e.lf);
        if (out_blend_factor !== e.bf)
          report_mismatch("blend_factor", out_blend_factor, e.bf);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 2000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_LOOP) model_loop = val[0];
    else model_count = val[8:0];
  endtask

  task automatic push_word(input logic op, input logic [7:0] slot, input logic [47:0] tv);
    word_t w;
    w = '{op, slot, tv};
    pending_words.insert(pending_words.size(), w);
  endtask

  // hold until every word is accepted and answered, then let the block settle
  task automatic drain();
    wait (pending_words.size() == 0);
    @(negedge clk);
    wait (expected_pairs.size() == 0 && !start);
    repeat (150) @(negedge clk);
  endtask

  // ascending table of n entries with random gaps; spread picks gap size
  task automatic load_table(input int n, input int spread);
    logic [47:0] t;
    t = 48'($urandom_range(spread));
    for (int i = 0; i < n; i++) begin
      push_word(kif_pkg::OP_WRITE, 8'(i), t);
      t = 48'(t + 1 + {$urandom, $urandom} % (64'd1 << spread));
    end
  endtask

  function automatic logic [47:0] rand_time(input int lim_bits);
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(5))
      0: return 48'({$urandom, $urandom});
      1: return 48'($urandom_range(3));
      default: return 48'(r % (64'd1 << lim_bits));
    endcase
  endfunction

  initial begin
    int n, sp;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    driving = 1'b1;
    reg_write(ADDR_LOOP, 32'd0);
    reg_write(ADDR_COUNT, 32'd0);

    // directed: queries on an empty count, then a small table and its edges
    push_word(kif_pkg::OP_WRITE, 8'd0, 48'd100);
    push_word(kif_pkg::OP_QUERY, 8'hff, 48'd50);
    push_word(kif_pkg::OP_QUERY, 8'd0, 48'h8000_0000_0000);
    push_word(kif_pkg::OP_WRITE, 8'd1, 48'd200);
    push_word(kif_pkg::OP_WRITE, 8'd2, 48'd1000);
    push_word(kif_pkg::OP_WRITE, 8'd255, 48'h7fff_ffff_ffff);
    drain();
    reg_write(ADDR_COUNT, 32'd1);
    push_word(kif_pkg::OP_QUERY, 8'd0, 48'd100);
    drain();
    reg_write(ADDR_COUNT, 32'd3);
    push_word(kif_pkg::OP_QUERY, 8'd0, 48'd99);
    push_word(kif_pkg::OP_QUERY, 8'd0, 48'd100);
    push_word(kif_pkg::OP_QUERY, 8'd0, 48'd150);
    push_word(kif_pkg::OP_QUERY, 8'd0, 48'd999);
    push_word(kif_pkg::OP_QUERY, 8'd0, 48'd1000);
    push_word(kif_pkg::OP_QUERY, 8'd0, 48'h7fff_ffff_ffff);
    push_word(kif_pkg::OP_QUERY, 8'd0, 48'hffff_ffff_ffff);
    drain();
    reg_write(ADDR_LOOP, 32'd1);
    push_word(kif_pkg::OP_QUERY, 8'd0, 48'd0);
    push_word(kif_pkg::OP_QUERY, 8'd0, 48'd50);
    push_word(kif_pkg::OP_QUERY, 8'd0, 48'd1150);
    push_word(kif_pkg::OP_QUERY, 8'd0, 48'h7fff_ffff_ffff);
    drain();
    // zero duration, then an unordered table with a negative duration
    push_word(kif_pkg::OP_WRITE, 8'd2, 48'd0);
    push_word(kif_pkg::OP_QUERY, 8'd0, 48'd5);
    push_word(kif_pkg::OP_WRITE, 8'd2, -48'sd300);
    push_word(kif_pkg::OP_QUERY, 8'd0, 48'd250);
    drain();

    // random phases: idling profile, loop mode and count change per phase
    for (int ph = 0; ph < 12; ph++) begin
      send_idle_pct = ph < 4 ? 20 : (ph < 8 ? 57 : 0);
      n = (ph == 11) ? 256 : $urandom_range(2, 20);
      sp = (ph % 3 == 0) ? 46 : $urandom_range(4, 20);
      if (n == 256) sp = 30;
      load_table(n, sp);
      drain();
      reg_write(ADDR_LOOP, 32'(ph % 2));
      // frame count beyond the table saturates, so only past 256 when full
      reg_write(ADDR_COUNT, n == 256 ? 32'h1ff : 32'(n));
      for (int i = 0; i < 30; i++) begin
        if ($urandom_range(9) == 0)
          push_word(kif_pkg::OP_WRITE, 8'($urandom_range(n, 255)), 48'({$urandom, $urandom}));
        else
          push_word(kif_pkg::OP_QUERY, 8'($urandom), rand_time(sp + 3 + $clog2(n)));
      end
      drain();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
